@@ rtl/core/amcf_pkg.sv @@
// Shared types and constants for the arm move command framer.
// Used by amcf_ctrl, amcf_dp and arm_move_command_framer; no dependencies.
package amcf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int COORD_W = 16;
  localparam int SPEED_W = 16;
  localparam int WAIT_W  = 16;
  localparam int KIND_W  = 2;
  localparam int ENTRY_W = 3 * COORD_W + 1 + KIND_W + SPEED_W + WAIT_W;

  localparam int WORD_W   = 18;
  localparam int MAG_W    = 17;
  localparam int POS_W    = 5;
  localparam int WIDX_W   = 4;

  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(9);

  localparam logic [7:0] FRAME_SOF = 8'hA5;
  localparam logic [7:0] FRAME_EOF = 8'h5A;

  localparam logic signed [WORD_W-1:0] OP_SPEED    = WORD_W'(10);
  localparam logic signed [WORD_W-1:0] SPEED_PARAM = WORD_W'(50);
  localparam logic signed [WORD_W-1:0] OP_MOVE     = WORD_W'(3);

  typedef logic signed [WORD_W-1:0] word_val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CONV_A,
    ST_CONV_B,
    ST_CONV_C,
    ST_BYTES,
    ST_TAIL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_DATA,
    SEL_TAIL
  } emit_sel_t;

  typedef enum logic [1:0] {
    STEP_SPEED,
    STEP_MOVE,
    STEP_WAIT,
    STEP_NONE
  } step_t;

  typedef struct packed {
    logic      push;
    logic      skip;
    logic      start;
    logic      conv_a;
    logic      conv_b;
    logic      conv_c;
    logic      emit;
    emit_sel_t sel;
    logic      next_byte;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic  q_empty;
    step_t step;
    logic  byte_last;
    logic  word_last;
    logic  out_free;
  } dp_status_t;

endpackage

@@ rtl/core/amcf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/amcf_ctrl.sv @@
// Frame sequencing state machine: accepts transactions, steps conversion and byte emission.
// Depends on amcf_pkg.
module amcf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic                 req_type,
  input  amcf_pkg::dp_status_t status,
  output amcf_pkg::dp_cmd_t    cmd,
  output logic                 in_stall
);
  import amcf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_HEAD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (!req_type) begin
            cmd.push = 1'b1;
          end else if (status.step == STEP_NONE || status.q_empty) begin
            cmd.skip = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_HEAD;
          state_nxt = ST_CONV_A;
        end
      end
      ST_CONV_A: begin
        cmd.conv_a = 1'b1;
        state_nxt  = ST_CONV_B;
      end
      ST_CONV_B: begin
        cmd.conv_b = 1'b1;
        state_nxt  = ST_CONV_C;
      end
      ST_CONV_C: begin
        cmd.conv_c = 1'b1;
        state_nxt  = ST_BYTES;
      end
      ST_BYTES: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = SEL_DATA;
          cmd.next_byte = 1'b1;
          if (status.byte_last) begin
            state_nxt = status.word_last ? ST_TAIL : ST_CONV_A;
          end
        end
      end
      ST_TAIL: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_TAIL;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

@@ rtl/core/amcf_dp.sv @@
// Datapath: command queue, sequence step, integer-to-single conversion and output register.
// Depends on amcf_pkg and amcf_ram.
module amcf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  amcf_pkg::dp_cmd_t                  cmd,
  output amcf_pkg::dp_status_t               status,
  input  logic signed [amcf_pkg::COORD_W-1:0] target_x,
  input  logic signed [amcf_pkg::COORD_W-1:0] target_y,
  input  logic signed [amcf_pkg::COORD_W-1:0] target_z,
  input  logic                               suction_on,
  input  logic signed [amcf_pkg::KIND_W-1:0]  move_kind,
  input  logic [amcf_pkg::SPEED_W-1:0]        speed_value,
  input  logic [amcf_pkg::WAIT_W-1:0]         wait_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         frame_byte,
  output logic                               frame_last,
  output logic                               overflow_seen
);
  import amcf_pkg::*;

  logic [PTR_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  step_t             step_r;
  logic              ovf_r;
  logic [WIDX_W-1:0] word_idx_r;
  logic [1:0]        byte_idx_r;
  logic              sign_r;
  logic [MAG_W-1:0]  mag_r;
  logic [POS_W-1:0]  pos_r;
  logic [31:0]       float_r;
  logic              out_valid_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              ovf_out_r;

  logic [PTR_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic               full;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  logic signed [COORD_W-1:0] ent_x, ent_y, ent_z;
  logic                      ent_suction;
  logic signed [KIND_W-1:0]  ent_kind;
  logic [SPEED_W-1:0]        ent_speed;
  logic [WAIT_W-1:0]         ent_wait;

  word_val_t         word;
  word_val_t         word_neg;
  logic [POS_W-1:0]  lead;
  logic [23:0]       mant_sh;
  logic [7:0]        emit_byte;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign tail_sum = (PTR_W+1)'(head_r) + (PTR_W+1)'(count_r);
  assign tail     = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : tail_sum[PTR_W-1:0];
  assign wr_en    = cmd.push && !full;
  assign wr_entry = {wait_value, speed_value, move_kind, suction_on,
                     target_z, target_y, target_x};

  amcf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail),
    .wdata(wr_entry),
    .re   (cmd.start),
    .raddr(head_r),
    .rdata(rd_entry)
  );

  assign {ent_wait, ent_speed, ent_kind, ent_suction, ent_z, ent_y, ent_x} = rd_entry;

  // queue pointers, step and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      step_r  <= STEP_SPEED;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.skip) begin
        step_r <= STEP_SPEED;
      end
      if (cmd.finish) begin
        if (step_r == STEP_WAIT) begin
          step_r  <= STEP_SPEED;
          count_r <= count_r - CNT_W'(1);
          head_r  <= (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        end else begin
          step_r <= step_t'(step_r + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= '0;
      byte_idx_r <= '0;
    end else if (cmd.start) begin
      word_idx_r <= '0;
      byte_idx_r <= '0;
    end else if (cmd.next_byte) begin
      byte_idx_r <= byte_idx_r + 2'd1;
      if (byte_idx_r == 2'd3) begin
        word_idx_r <= word_idx_r + WIDX_W'(1);
      end
    end
  end

  // frame word for the current index
  always_comb begin
    word = '0;
    if (step_r == STEP_SPEED) begin
      unique case (word_idx_r)
        WIDX_W'(0): word = OP_SPEED;
        WIDX_W'(2): word = SPEED_PARAM;
        WIDX_W'(3),
        WIDX_W'(4): word = word_val_t'({2'b00, ent_speed});
        default:    word = '0;
      endcase
    end else begin
      unique case (word_idx_r)
        WIDX_W'(0): word = OP_MOVE;
        WIDX_W'(2): word = WORD_W'(ent_x);
        WIDX_W'(3): word = WORD_W'(ent_y);
        WIDX_W'(4): word = WORD_W'(ent_z);
        WIDX_W'(6): word = word_val_t'({17'd0, ent_suction});
        WIDX_W'(7): word = WORD_W'(ent_kind) + WORD_W'(1);
        WIDX_W'(9): word = (step_r == STEP_WAIT) ? word_val_t'({2'b00, ent_wait}) : '0;
        default:    word = '0;
      endcase
    end
  end

  assign word_neg = -word;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_r[i]) begin
        lead = POS_W'(i);
      end
    end
  end

  assign mant_sh = {7'd0, mag_r} << (POS_W'(23) - pos_r);

  // integer to single conversion in the steps conv_a, conv_b, conv_c
  always_ff @(posedge clk) begin
    if (cmd.conv_a) begin
      sign_r <= word[WORD_W-1];
      mag_r  <= word[WORD_W-1] ? word_neg[MAG_W-1:0] : word[MAG_W-1:0];
    end
    if (cmd.conv_b) begin
      pos_r <= lead;
    end
    if (cmd.conv_c) begin
      if (mag_r == '0) begin
        float_r <= '0;
      end else begin
        float_r <= {sign_r, 8'd127 + 8'(pos_r), mant_sh[22:0]};
      end
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_HEAD: emit_byte = FRAME_SOF;
      SEL_DATA: emit_byte = float_r[8*byte_idx_r +: 8];
      SEL_TAIL: emit_byte = FRAME_EOF;
      default:  emit_byte = FRAME_SOF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_r    <= emit_byte;
      last_r    <= (cmd.sel == SEL_TAIL);
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign frame_byte    = byte_r;
  assign frame_last    = last_r;
  assign overflow_seen = ovf_out_r;

  assign status.q_empty   = (count_r == '0);
  assign status.step      = step_r;
  assign status.byte_last = (byte_idx_r == 2'd3);
  assign status.word_last = (word_idx_r == LAST_WORD);
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

@@ rtl/core/arm_move_command_framer.sv @@
// Top level of the arm move command framer: controller plus datapath.
// Depends on amcf_pkg, amcf_ctrl, amcf_dp (and amcf_ram through amcf_dp).
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall   | req_type, target_x/y/z, suction_on, move_kind,
//           |                      | speed_value, wait_value
//   out     | out_valid / out_stall | frame_byte, frame_last, overflow_seen
//
// A push does not stall the input. A tick that emits a frame holds the input
// after it is accepted: the start byte, then per word the conversion steps conv_a,
// conv_b, conv_c and four bytes, then the end byte; output stalls hold it longer.
// Reset is synchronous, active low; queue contents are not cleared.
// A pending end byte never blocks acceptance of the next transaction.
module arm_move_command_framer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [amcf_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [amcf_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [amcf_pkg::COORD_W-1:0] in_target_z,
  input  logic                                in_suction_on,
  input  logic signed [amcf_pkg::KIND_W-1:0]  in_move_kind,
  input  logic [amcf_pkg::SPEED_W-1:0]        in_speed_value,
  input  logic [amcf_pkg::WAIT_W-1:0]         in_wait_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_frame_byte,
  output logic                                out_frame_last,
  output logic                                out_overflow_seen
);
  import amcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_accept;

  assign in_accept = in_valid && !in_stall;

  amcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .req_type (in_req_type),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  amcf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .target_x     (in_target_x),
    .target_y     (in_target_y),
    .target_z     (in_target_z),
    .suction_on   (in_suction_on),
    .move_kind    (in_move_kind),
    .speed_value  (in_speed_value),
    .wait_value   (in_wait_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (out_frame_byte),
    .frame_last   (out_frame_last),
    .overflow_seen(out_overflow_seen)
  );

endmodule
